[rtl/partition_allocator_first_best_fit_defines.svh]
// Assertion macros shared by the allocator checker.
`ifndef PARTITION_ALLOCATOR_FIRST_BEST_FIT_DEFINES_SVH
`define PARTITION_ALLOCATOR_FIRST_BEST_FIT_DEFINES_SVH

// Same-cycle implication, quiet while reset is applied.
`define PAFBF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, quiet while reset is applied.
`define PAFBF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

// Holds in the cycle after reset was low.
`define PAFBF_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) $past(!i_rst_n) |-> (cons)) \
        else $error("allocator reset check failed");

`endif

[rtl/pafbf_pkg.sv]
// Command and status codes of the partition allocator.
package pafbf_pkg;

    localparam logic [1:0] CMD_FIRST_FIT = 2'd0;
    localparam logic [1:0] CMD_BEST_FIT  = 2'd1;
    localparam logic [1:0] CMD_FREE      = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_FIT     = 2'd1;
    localparam logic [1:0] ST_NOT_USED   = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL = 2'd3;

endpackage

[rtl/partition_allocator_first_best_fit.sv]
// Variable partition allocator: first fit, best fit and free with coalescing.
// An allocation scans the segments in table order and, when a split opens a
// slot, moves each entry above the pick up one place; a free moves the
// entries above down one place when a merge closes a slot.
// One command at a time is taken: o_in_stall is high until the sequencer is idle.
// Reset (synchronous, active low) leaves one free segment over all memory.
module partition_allocator_first_best_fit #(
    parameter int MEM_UNITS   = 128,
    parameter int TABLE_DEPTH = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_request_size,
    input  logic [6:0] i_segment_index,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [6:0] o_result_index,
    output logic [6:0] o_block_start,
    output logic [7:0] o_block_size,
    output logic [7:0] o_used_total,
    output logic [7:0] o_free_total
);

    // Widths of segment start, segment size, table index and segment count.
    localparam int AW = $clog2(MEM_UNITS);
    localparam int SW = $clog2(MEM_UNITS + 1);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    // Compare widths wide enough for both operands.
    localparam int W  = ((SW > 8) ? SW : 8) + 1;
    localparam int IX = (CW > 7) ? CW : 7;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_DECIDE,
        S_SHR_RD,
        S_SHR_WR,
        S_SPLIT,
        S_SPLIT2,
        S_F_RD,
        S_F_EV,
        S_F_R_RD,
        S_F_R_EV,
        S_SHL_RD,
        S_SHL_WR,
        S_F_L_RD,
        S_F_L_EV,
        S_F_FIN,
        S_DONE
    } t_state;

    // Segment table: start, size and a used flag per entry. Entries at or
    // above the segment count are never used, so the table needs no clear.
    logic [AW-1:0] mem_start [TABLE_DEPTH];
    logic [SW-1:0] mem_size  [TABLE_DEPTH];
    logic          mem_used  [TABLE_DEPTH];

    t_state        r_state;
    logic [1:0]    r_cmd;
    logic [7:0]    r_req;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_k;
    logic          r_found;
    logic          r_ret;
    logic [IW-1:0] r_pick;
    logic [AW-1:0] r_pstart;
    logic [SW-1:0] r_psize;
    logic [AW-1:0] r_cstart;
    logic [SW-1:0] r_csize;
    logic [CW-1:0] r_count;
    logic [SW-1:0] r_used;
    logic [7:0]    r_minrem;
    logic          r_e0_ok;
    logic          r_rd_dflt;
    logic [AW-1:0] r_rd_start;
    logic [SW-1:0] r_rd_size;
    logic          r_rd_used;
    logic [1:0]    r_res_status;
    logic [IW-1:0] r_res_idx;
    logic [AW-1:0] r_res_start;
    logic [SW-1:0] r_res_size;
    logic          r_o_valid;
    logic [1:0]    r_o_status;
    logic [6:0]    r_o_index;
    logic [6:0]    r_o_start;
    logic [7:0]    r_o_size;
    logic [7:0]    r_o_used;
    logic [7:0]    r_o_free;

    logic [IW-1:0] w_raddr;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [AW-1:0] w_wstart;
    logic [SW-1:0] w_wsize;
    logic          w_wused;
    logic [AW-1:0] rd_start;
    logic [SW-1:0] rd_size;
    logic          rd_used;
    logic          in_xfer;
    logic          idx_ok;
    logic          fits;
    logic [SW-1:0] rem;
    logic          rem_small;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign idx_ok     = IX'(i_segment_index) < IX'(r_count);

    // Entry 0 reads as the whole free memory until it is first written.
    assign rd_start = r_rd_dflt ? '0 : r_rd_start;
    assign rd_size  = r_rd_dflt ? SW'(MEM_UNITS) : r_rd_size;
    assign rd_used  = r_rd_dflt ? 1'b0 : r_rd_used;

    assign fits = !rd_used && (r_req != 8'd0) && (W'(rd_size) >= W'(r_req));
    assign rem       = r_psize - SW'(r_req);
    assign rem_small = W'(rem) <= W'(r_minrem);

    // Table port control, decoded from the sequencer state.
    always_comb begin
        w_raddr  = '0;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wstart = '0;
        w_wsize  = '0;
        w_wused  = 1'b0;
        case (r_state)
            S_SCAN_RD: w_raddr = r_i[IW-1:0];
            S_DECIDE: begin
                // whole segment handed out: mark it used
                w_we     = r_found && rem_small;
                w_waddr  = r_pick;
                w_wstart = r_pstart;
                w_wsize  = r_psize;
                w_wused  = 1'b1;
            end
            S_SHR_RD: w_raddr = IW'(r_k - 1'b1);
            S_SHR_WR, S_SHL_WR: begin
                w_we     = 1'b1;
                w_waddr  = r_k[IW-1:0];
                w_wstart = rd_start;
                w_wsize  = rd_size;
                w_wused  = rd_used;
            end
            S_SPLIT: begin
                // free remainder goes in the slot after the pick
                w_we     = 1'b1;
                w_waddr  = r_pick + 1'b1;
                w_wstart = AW'(r_pstart + r_req);
                w_wsize  = rem;
                w_wused  = 1'b0;
            end
            S_SPLIT2: begin
                w_we     = 1'b1;
                w_waddr  = r_pick;
                w_wstart = r_pstart;
                w_wsize  = SW'(r_req);
                w_wused  = 1'b1;
            end
            S_F_RD:   w_raddr = r_idx;
            S_F_R_RD: w_raddr = r_idx + 1'b1;
            S_SHL_RD: w_raddr = IW'(r_k + 1'b1);
            S_F_L_RD: w_raddr = r_idx - 1'b1;
            S_F_FIN: begin
                w_we     = 1'b1;
                w_waddr  = r_idx;
                w_wstart = r_cstart;
                w_wsize  = r_csize;
                w_wused  = 1'b0;
            end
            default: w_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_start[w_waddr] <= w_wstart;
            mem_size[w_waddr]  <= w_wsize;
            mem_used[w_waddr]  <= w_wused;
        end
        r_rd_start <= mem_start[w_raddr];
        r_rd_size  <= mem_size[w_raddr];
        r_rd_used  <= mem_used[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_ok   <= 1'b0;
            r_rd_dflt <= 1'b0;
        end else begin
            if (w_we && (w_waddr == '0)) begin
                r_e0_ok <= 1'b1;
            end
            r_rd_dflt <= (w_raddr == '0) && !r_e0_ok;
        end
    end

    // Sequencer, bookkeeping and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= CW'(1);
            r_used    <= '0;
            r_minrem  <= 8'd2;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_minrem <= i_cfg_wdata;
            end
            // drop the result once it has been taken, unless a new one lands now
            if (r_o_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cmd   <= i_command;
                        r_req   <= i_request_size;
                        r_idx   <= IW'(i_segment_index);
                        r_i     <= '0;
                        r_found <= 1'b0;
                        r_res_status <= pafbf_pkg::ST_NOT_USED;
                        r_res_idx    <= '0;
                        r_res_start  <= '0;
                        r_res_size   <= '0;
                        case (i_command)
                            pafbf_pkg::CMD_FIRST_FIT,
                            pafbf_pkg::CMD_BEST_FIT: r_state <= S_SCAN_RD;
                            pafbf_pkg::CMD_FREE:
                                r_state <= idx_ok ? S_F_RD : S_DONE;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN_RD: begin
                    r_state <= (r_i == r_count) ? S_DECIDE : S_SCAN_EV;
                end
                S_SCAN_EV: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= S_SCAN_RD;
                    if (fits && (!r_found || (r_cmd == pafbf_pkg::CMD_BEST_FIT
                                              && rd_size < r_psize))) begin
                        r_found  <= 1'b1;
                        r_pick   <= r_i[IW-1:0];
                        r_pstart <= rd_start;
                        r_psize  <= rd_size;
                        if (r_cmd == pafbf_pkg::CMD_FIRST_FIT) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    if (!r_found) begin
                        r_res_status <= pafbf_pkg::ST_NO_FIT;
                        r_state      <= S_DONE;
                    end else if (rem_small) begin
                        r_used       <= r_used + r_psize;
                        r_res_status <= pafbf_pkg::ST_OK;
                        r_res_idx    <= r_pick;
                        r_res_start  <= r_pstart;
                        r_res_size   <= r_psize;
                        r_state      <= S_DONE;
                    end else if (r_count == CW'(TABLE_DEPTH)) begin
                        r_res_status <= pafbf_pkg::ST_TABLE_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_k     <= r_count;
                        r_state <= S_SHR_RD;
                    end
                end
                S_SHR_RD: begin
                    r_state <= (r_k == CW'(r_pick) + 1'b1) ? S_SPLIT : S_SHR_WR;
                end
                S_SHR_WR: begin
                    r_k     <= r_k - 1'b1;
                    r_state <= S_SHR_RD;
                end
                S_SPLIT: r_state <= S_SPLIT2;
                S_SPLIT2: begin
                    r_count      <= r_count + 1'b1;
                    r_used       <= r_used + SW'(r_req);
                    r_res_status <= pafbf_pkg::ST_OK;
                    r_res_idx    <= r_pick;
                    r_res_start  <= r_pstart;
                    r_res_size   <= SW'(r_req);
                    r_state      <= S_DONE;
                end
                S_F_RD: r_state <= S_F_EV;
                S_F_EV: begin
                    if (!rd_used) begin
                        r_state <= S_DONE;
                    end else begin
                        r_used   <= r_used - rd_size;
                        r_cstart <= rd_start;
                        r_csize  <= rd_size;
                        r_state  <= (CW'(r_idx) + 1'b1 < r_count) ? S_F_R_RD : S_F_L_RD;
                    end
                end
                S_F_R_RD: r_state <= S_F_R_EV;
                S_F_R_EV: begin
                    if (!rd_used) begin
                        // absorb the free right neighbour and close its slot
                        r_csize <= r_csize + rd_size;
                        r_k     <= CW'(r_idx) + 1'b1;
                        r_ret   <= 1'b0;
                        r_state <= S_SHL_RD;
                    end else begin
                        r_state <= S_F_L_RD;
                    end
                end
                S_SHL_RD: begin
                    if (r_k + 1'b1 == r_count) begin
                        r_count <= r_count - 1'b1;
                        r_state <= r_ret ? S_F_FIN : S_F_L_RD;
                    end else begin
                        r_state <= S_SHL_WR;
                    end
                end
                S_SHL_WR: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= S_SHL_RD;
                end
                S_F_L_RD: begin
                    r_state <= (r_idx != '0) ? S_F_L_EV : S_F_FIN;
                end
                S_F_L_EV: begin
                    if (!rd_used) begin
                        // fold into the free left neighbour
                        r_cstart <= rd_start;
                        r_csize  <= rd_size + r_csize;
                        r_k      <= CW'(r_idx);
                        r_idx    <= r_idx - 1'b1;
                        r_ret    <= 1'b1;
                        r_state  <= S_SHL_RD;
                    end else begin
                        r_state <= S_F_FIN;
                    end
                end
                S_F_FIN: begin
                    r_res_status <= pafbf_pkg::ST_OK;
                    r_res_idx    <= r_idx;
                    r_res_start  <= r_cstart;
                    r_res_size   <= r_csize;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_o_valid || !i_out_stall) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_res_status;
                        r_o_index  <= 7'(r_res_idx);
                        r_o_start  <= 7'(r_res_start);
                        r_o_size   <= 8'(r_res_size);
                        r_o_used   <= 8'(r_used);
                        r_o_free   <= 8'(SW'(MEM_UNITS) - r_used);
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_result_index = r_o_index;
    assign o_block_start  = r_o_start;
    assign o_block_size   = r_o_size;
    assign o_used_total   = r_o_used;
    assign o_free_total   = r_o_free;

endmodule

[rtl/pafbf_checker.sv]
// Port-level checker for the allocator, bound to the top level.
`include "partition_allocator_first_best_fit_defines.svh"

module pafbf_checker #(
    parameter int MEM_UNITS = 128
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_status,
    input logic [6:0] o_result_index,
    input logic [6:0] o_block_start,
    input logic [7:0] o_block_size,
    input logic [7:0] o_used_total,
    input logic [7:0] o_free_total
);

    `PAFBF_ASSERT_NXT(a_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_status))
    `PAFBF_ASSERT_IMP(a_fail_zero, o_out_valid && (o_status != pafbf_pkg::ST_OK), (o_result_index == 7'd0) && (o_block_start == 7'd0) && (o_block_size == 8'd0))
    `PAFBF_ASSERT_IMP(a_totals, o_out_valid, 8'(o_used_total + o_free_total) == 8'(MEM_UNITS))
    `PAFBF_ASSERT_RST(a_reset_idle, !o_out_valid)

endmodule

bind partition_allocator_first_best_fit pafbf_checker #(.MEM_UNITS(MEM_UNITS)) u_pafbf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_result_index (o_result_index),
    .o_block_start  (o_block_start),
    .o_block_size   (o_block_size),
    .o_used_total   (o_used_total),
    .o_free_total   (o_free_total)
);
